[design/tbrl_pkg.sv]
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Field widths, operation codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  localparam int FRAC_BITS = 30;
  localparam int TIME_W    = 64;
  localparam int RATE_W    = 40;
  localparam int CAP_W     = 32;
  localparam int AMOUNT_W  = 32;
  localparam int LEVEL_W   = CAP_W + FRAC_BITS;
  localparam int PROD_W    = TIME_W + RATE_W;
  localparam int NS_W      = 30;
  localparam int DIV_STEPS = TIME_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int CFG_W     = RATE_W;

  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);

  // Products at or above one second of ns scaled by 2^32 saturate the refill.
  localparam logic [PROD_W-1:0] SAT_LIMIT =
    {{(PROD_W - NS_W - 32){1'b0}}, NS_PER_SEC, 32'b0};

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_REFILL  = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_REFUND  = 2'd3;

  localparam logic REG_FILL_RATE = 1'b0;
  localparam logic REG_BURST_CAP = 1'b1;

endpackage

[design/token_bucket_rate_limiter_top.sv]
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Byte token bucket with clear, timed refill, consume and refund operations.
// ----------------------------------------------------------------------------
// Clear, consume and refund go from idle to the finish step, which registers
// the result beat; a refill that only records time or sees zero rate or cap
// goes through setup to finish. A full refill runs a bit-serial 64x40 multiply
// (one rate bit per step), a saturation check and a restoring divide by 1e9
// (one quotient bit per step). One item is in work at a time; the next beat
// can be taken in the cycle after the result loads. Synchronous reset empties
// the bucket, clears the refill time and registers, and holds the input off.
module token_bucket_rate_limiter_top
  import tbrl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,   // now_ns[63:0], amount_bytes[95:64]
  input  logic [1:0]          s_axis_tuser,   // op[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // result_bytes[31:0]
  input  logic                cfg_wen,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]          state;
  logic [RATE_W-1:0]   fill_rate;
  logic [CAP_W-1:0]    burst_cap;
  logic [LEVEL_W-1:0]  level;
  logic [TIME_W-1:0]   last_time;
  logic                refill_valid;
  logic [CNT_W-1:0]    cnt;
  logic                out_valid;
  logic [CAP_W-1:0]    out_data;

  logic [1:0]          op;
  logic [TIME_W-1:0]   now;
  logic [AMOUNT_W-1:0] amount;
  logic                skip;
  logic [PROD_W-1:0]   prod;
  logic [NS_W-1:0]     rem;
  logic [LEVEL_W-1:0]  quo;

  logic                in_fire;
  logic                fin_fire;
  logic [TIME_W:0]     mul_sum;
  logic [NS_W:0]       div_try;
  logic                div_ge;
  logic [NS_W:0]       div_diff;
  logic [LEVEL_W-1:0]  cap_fixed;
  logic [AMOUNT_W-1:0] whole;
  logic [AMOUNT_W-1:0] grant;
  logic [LEVEL_W-1:0]  addend;
  logic [LEVEL_W:0]    level_sum;
  logic [LEVEL_W-1:0]  level_capped;
  logic [LEVEL_W-1:0]  level_next;
  logic [CAP_W-1:0]    result;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign fin_fire      = (state == ST_FIN) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign mul_sum  = {1'b0, prod[PROD_W-1:RATE_W]} + (prod[0] ? {1'b0, now} : '0);
  assign div_try  = {rem, prod[PROD_W-1]};
  assign div_ge   = div_try >= {1'b0, NS_PER_SEC};
  assign div_diff = div_try - {1'b0, NS_PER_SEC};

  assign cap_fixed = {burst_cap, {FRAC_BITS{1'b0}}};
  assign whole     = level[LEVEL_W-1:FRAC_BITS];
  assign grant     = (amount < whole) ? amount : whole;
  assign addend    = (op == OP_REFUND) ? {amount, {FRAC_BITS{1'b0}}} : quo;
  assign level_sum = {1'b0, level} + {1'b0, addend};
  assign level_capped = (level_sum > {1'b0, cap_fixed}) ? cap_fixed
                                                        : level_sum[LEVEL_W-1:0];

  always_comb begin
    level_next = level;
    result     = '0;
    case (op)
      OP_CLEAR: begin
        level_next = '0;
      end
      OP_REFILL: begin
        if (!skip) begin
          level_next = level_capped;
          result     = level_capped[LEVEL_W-1:FRAC_BITS];
        end
      end
      OP_CONSUME: begin
        level_next = level - {grant, {FRAC_BITS{1'b0}}};
        result     = grant;
      end
      OP_REFUND: begin
        if (amount != '0 && burst_cap != '0) begin
          level_next = level_capped;
        end
      end
      default: begin
        level_next = level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_rate    <= '0;
      burst_cap    <= '0;
      level        <= '0;
      last_time    <= '0;
      refill_valid <= 1'b0;
      cnt          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_FILL_RATE: fill_rate <= cfg_data;
          REG_BURST_CAP: burst_cap <= cfg_data[CAP_W-1:0];
          default:       fill_rate <= fill_rate;
        endcase
      end

      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (s_axis_tuser == OP_REFILL) ? ST_SETUP : ST_FIN;
          end
        end
        ST_SETUP: begin
          if (fill_rate == '0 || burst_cap == '0) begin
            state <= ST_FIN;
          end else if (!refill_valid || now < last_time) begin
            last_time    <= now;
            refill_valid <= 1'b1;
            level        <= '0;
            state        <= ST_FIN;
          end else begin
            last_time <= now;
            cnt       <= CNT_W'(RATE_W);
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (prod >= SAT_LIMIT) begin
            state <= ST_FIN;
          end else begin
            cnt   <= CNT_W'(DIV_STEPS);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            level <= level_next;
            if (op == OP_CLEAR) begin
              last_time    <= '0;
              refill_valid <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op     <= s_axis_tuser;
      now    <= s_axis_tdata[TIME_W-1:0];
      amount <= s_axis_tdata[TIME_W +: AMOUNT_W];
      skip   <= 1'b1;
    end
    case (state)
      ST_SETUP: begin
        if (fill_rate != '0 && burst_cap != '0 && refill_valid && now >= last_time) begin
          now  <= now - last_time;
          prod <= {{TIME_W{1'b0}}, fill_rate};
          skip <= 1'b0;
        end
      end
      ST_MUL: begin
        prod <= {mul_sum, prod[RATE_W-1:1]};
      end
      ST_CHK: begin
        if (prod >= SAT_LIMIT) begin
          quo <= cap_fixed;
        end else begin
          prod <= {prod[TIME_W-1:0], {RATE_W{1'b0}}};
          rem  <= '0;
          quo  <= '0;
        end
      end
      ST_DIV: begin
        prod <= {prod[PROD_W-2:0], 1'b0};
        rem  <= div_ge ? div_diff[NS_W-1:0] : div_try[NS_W-1:0];
        quo  <= {quo[LEVEL_W-2:0], div_ge};
      end
      default: begin
        quo <= quo;
      end
    endcase
    if (fin_fire) begin
      out_data <= result;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < NS_PER_SEC))
    else $error("divider remainder out of range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result beat raised outside the finish step");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt != '0 && cnt <= CNT_W'(RATE_W)))
    else $error("multiplier step count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_SETUP || state == ST_FIN))
    else $error("accepted beat did not start work");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Token bucket rate limiter testbench
// Drives clear, refill, consume and refund beats with random gaps and output
// stalls across many fill rate and burst cap settings. A scoreboard class
// predicts the granted and available byte counts in fixed point and checks
// every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tbrl_pkg::*;

  class bucket_scoreboard;
    logic [RATE_W-1:0]   rate;
    logic [CAP_W-1:0]    cap;
    logic [LEVEL_W-1:0]  level;
    logic [TIME_W-1:0]   last_ns;
    bit                  time_known;
    logic [AMOUNT_W-1:0] pending_bytes[$];
    int                  requests;
    int                  checked;
    int                  errors;

    function new();
      rate       = '0;
      cap        = '0;
      level      = '0;
      last_ns    = '0;
      time_known = 1'b0;
      requests   = 0;
      checked    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_FILL_RATE) begin
        rate = data[RATE_W-1:0];
      end else begin
        cap = data[CAP_W-1:0];
      end
    endfunction

    function void log_request(logic [1:0] op, logic [TIME_W-1:0] now,
                              logic [AMOUNT_W-1:0] amt);
      logic [63:0]         cap_fx;
      logic [63:0]         q;
      logic [63:0]         sum;
      logic [63:0]         whole;
      logic [127:0]        prod;
      logic [AMOUNT_W-1:0] bytes;
      cap_fx = {32'b0, cap} << FRAC_BITS;
      bytes  = '0;
      requests++;
      case (op)
        OP_CLEAR: begin
          level      = '0;
          last_ns    = '0;
          time_known = 1'b0;
        end
        OP_REFILL: begin
          if (rate == 0 || cap == 0) begin
            bytes = '0;
          end else if (!time_known || now < last_ns) begin
            last_ns    = now;
            time_known = 1'b1;
            level      = '0;
          end else begin
            prod    = 128'(now - last_ns) * 128'(rate);
            last_ns = now;
            if (prod >= (128'(NS_PER_SEC) << 32)) begin
              q = cap_fx;
            end else begin
              q = 64'((prod << FRAC_BITS) / 128'(NS_PER_SEC));
              if (q > cap_fx) q = cap_fx;
            end
            sum = 64'(level) + q;
            if (sum > cap_fx) sum = cap_fx;
            level = sum[LEVEL_W-1:0];
            bytes = AMOUNT_W'(sum >> FRAC_BITS);
          end
        end
        OP_CONSUME: begin
          whole = 64'(level) >> FRAC_BITS;
          bytes = (64'(amt) < whole) ? amt : whole[AMOUNT_W-1:0];
          level = LEVEL_W'(64'(level) - (64'(bytes) << FRAC_BITS));
        end
        default: begin
          if (amt != 0 && cap != 0) begin
            sum = 64'(level) + (64'(amt) << FRAC_BITS);
            if (sum > cap_fx) sum = cap_fx;
            level = sum[LEVEL_W-1:0];
          end
        end
      endcase
      pending_bytes.push_back(bytes);
    endfunction

    function void match_response(logic [AMOUNT_W-1:0] got);
      logic [AMOUNT_W-1:0] want;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: result_bytes expected none got %0d", $time, got);
        return;
      end
      want = pending_bytes.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: result_bytes expected %0d got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata  = '0;
  logic [1:0]        s_axis_tuser  = OP_CLEAR;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              cfg_wen       = 1'b0;
  logic              cfg_index     = REG_FILL_RATE;
  logic [CFG_W-1:0]  cfg_data      = '0;

  bucket_scoreboard  sb;
  bit                no_idle    = 1'b0;
  int                stall_left = 0;
  int                reg_writes = 0;
  logic [63:0]       stamp_ns   = '0;

  token_bucket_rate_limiter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 40'd1;
      2: return 40'($urandom_range(1, 1000));
      3, 4: return 40'($urandom_range(1000000, 2000000000));
      5, 6: return 40'($urandom);
      7: return {8'($urandom_range(0, 255)), 32'($urandom)};
      8: return {RATE_W{1'b1}};
      default: return 40'd1000000000;
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2, 3: return 32'($urandom_range(1, 100));
      4, 5: return 32'($urandom_range(1, 100000));
      6, 7: return 32'($urandom);
      8: return {CAP_W{1'b1}};
      default: return 32'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [63:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, 2000));
      4, 5, 6: return 64'($urandom_range(0, 2000000));
      7, 8: return 64'($urandom);
      default: return {24'b0, 8'($urandom_range(0, 255)), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 64));
      4, 5, 6: return 32'($urandom_range(0, 65535));
      7, 8: return 32'($urandom);
      default: return $urandom_range(0, 1) ? {AMOUNT_W{1'b1}} : '0;
    endcase
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [63:0] now,
                          input logic [31:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {amt, now};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.log_request(op, now, amt);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [RATE_W-1:0] rate, input logic [CAP_W-1:0] cap);
    settle();
    write_reg(REG_FILL_RATE, rate);
    write_reg(REG_BURST_CAP, CFG_W'(cap));
  endtask

  task automatic random_phase(input int n);
    logic [1:0]  op;
    logic [63:0] now;
    int          r;
    set_regs(pick_rate(), pick_cap());
    no_idle = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      op = (r < 6) ? OP_CLEAR : (r < 48) ? OP_REFILL : (r < 78) ? OP_CONSUME : OP_REFUND;
      now = {32'($urandom), 32'($urandom)};
      if (op == OP_REFILL) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          stamp_ns = stamp_ns - 64'($urandom_range(1, 100000));
        end else if (r < 13) begin
          stamp_ns = {32'($urandom), 32'($urandom)};
        end else if (r >= 18) begin
          stamp_ns = stamp_ns + pick_step();
        end
        now = stamp_ns;
      end
      send_req(op, now, pick_amount());
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.match_response(m_axis_tdata);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: zero rate and cap.
    send_req(OP_REFILL, 64'd500, 32'd0);
    send_req(OP_CONSUME, 64'd0, 32'd5);
    send_req(OP_REFUND, 64'd0, 32'd10);

    set_regs(40'd1000000000, 32'd1000);
    send_req(OP_REFILL, 64'd100, 32'd0);
    send_req(OP_REFILL, 64'd600, 32'd0);
    send_req(OP_REFILL, 64'd2000, 32'd0);
    send_req(OP_CONSUME, {64{1'b1}}, 32'd0);
    send_req(OP_CONSUME, 64'd0, 32'd300);
    send_req(OP_CONSUME, 64'd0, {32{1'b1}});
    send_req(OP_REFUND, 64'd0, 32'd0);
    send_req(OP_REFUND, 64'd0, 32'd50);
    send_req(OP_REFUND, 64'd0, {32{1'b1}});
    send_req(OP_REFILL, 64'd1000, 32'd0);
    send_req(OP_REFILL, 64'd1000, 32'd0);
    send_req(OP_CLEAR, 64'd0, 32'd0);
    send_req(OP_REFILL, 64'd5000, 32'd0);
    send_req(OP_REFILL, {64{1'b1}}, 32'd0);

    set_regs({RATE_W{1'b1}}, {CAP_W{1'b1}});
    send_req(OP_REFILL, 64'd0, 32'd0);
    send_req(OP_REFILL, 64'd1, 32'd0);
    send_req(OP_REFILL, {64{1'b1}}, 32'd0);
    send_req(OP_CONSUME, 64'd0, {32{1'b1}});

    // A refill just short of one whole token truncates to zero.
    set_regs(40'd3, 32'd5);
    send_req(OP_REFILL, 64'd10, 32'd0);
    send_req(OP_REFILL, 64'd333333343, 32'd0);
    send_req(OP_REFILL, 64'd333333344, 32'd0);

    // Lowering the cap leaves the held tokens available to consume.
    set_regs(40'd1000000000, 32'd1000);
    send_req(OP_REFILL, 64'd333336000, 32'd0);
    settle();
    write_reg(REG_BURST_CAP, CFG_W'(32'd10));
    send_req(OP_CONSUME, 64'd0, 32'd500);
    send_req(OP_REFUND, 64'd0, 32'd1);

    stamp_ns = 64'd0;
    for (int p = 0; p < 10; p++) random_phase(80);

    settle();
    repeat (150) @(posedge clk);
    $display("Summary: %0d request beats over %0d register writes, %0d result beats checked.",
             sb.requests, reg_writes, sb.checked);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("token_bucket_rate_limiter_top: match");
    end else begin
      $display("token_bucket_rate_limiter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("token_bucket_rate_limiter_top: mismatch");
    $finish;
  end

endmodule
